@@ hw/rtl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths and angle constants of the quaternion to Euler core.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int QW     = 32;  // Q30 component width
  localparam int PW     = 34;  // product after the Q60 to Q30 shift
  localparam int SW     = 38;  // sums feeding the atan2 lanes
  localparam int AW_IN  = 32;  // saturated asin argument
  localparam int RAD_W  = 61;  // 2^60 - a^2
  localparam int ROOT_W = 31;  // floor sqrt of the radicand
  localparam int CW     = 40;  // CORDIC x/y datapath
  localparam int OUT_W  = 17;
  localparam int OFF_W  = 16;
  localparam int ATAN_TBL_LEN = 24;
  localparam int HUNDREDTHS_PER_RAD = 5730;
  localparam int ANGLE_LIMIT = 36000;

  localparam longint PI_Q30 = 64'sd3373259426;

  localparam longint ATAN_Q30 [ATAN_TBL_LEN] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef enum logic [1:0] {
    CFG_PITCH_OFFSET = 2'd0,
    CFG_ROLL_OFFSET  = 2'd1,
    CFG_YAW_OFFSET   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] x;
  } vec_t;

  // Q30 value converted to the angle format, round to nearest
  function automatic longint q30_to_angle(input longint v, input int frac_bits);
    int sh;
    sh = 30 - frac_bits;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint atan_angle(input int i, input int frac_bits);
    return q30_to_angle(ATAN_Q30[i], frac_bits);
  endfunction

  function automatic longint pi_angle(input int frac_bits);
    return q30_to_angle(PI_Q30, frac_bits);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front
// Quaternion products, angle argument sums and the asin cosine radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front
  import qte_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_vld,
  input  wire  signed [QW-1:0]     quat_w,
  input  wire  signed [QW-1:0]     quat_x,
  input  wire  signed [QW-1:0]     quat_y,
  input  wire  signed [QW-1:0]     quat_z,
  output logic                     out_vld,
  output logic signed [AW_IN-1:0]  asin_arg,
  output logic        [RAD_W-1:0]  radicand,
  output vec_t                     roll_vec,
  output vec_t                     yaw_vec
);

  // stage 0: input register
  logic                 v0_r;
  logic signed [QW-1:0] w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= in_vld;
    w_r <= quat_w;
    x_r <= quat_x;
    y_r <= quat_y;
    z_r <= quat_z;
  end

  // stage 1: ten products, floor shifted back to Q30
  logic v1_r;
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, wy_r, wz_r, xy_r, xz_r, yz_r;

  function automatic logic signed [PW-1:0] qmul(input logic signed [QW-1:0] p,
                                                 input logic signed [QW-1:0] q);
    logic signed [2*QW-1:0] full;
    full = p * q;
    return full[2*QW-1:30];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
    ww_r <= qmul(w_r, w_r);
    xx_r <= qmul(x_r, x_r);
    yy_r <= qmul(y_r, y_r);
    zz_r <= qmul(z_r, z_r);
    wx_r <= qmul(w_r, x_r);
    wy_r <= qmul(w_r, y_r);
    wz_r <= qmul(w_r, z_r);
    xy_r <= qmul(x_r, y_r);
    xz_r <= qmul(x_r, z_r);
    yz_r <= qmul(y_r, z_r);
  end

  // stage 2: sums, asin argument clamped to +/-1.0
  localparam logic signed [SW-1:0] ONE_Q30 = SW'(64'sd1 <<< 30);

  logic signed [SW-1:0] a_full;
  logic signed [AW_IN-1:0] a_sat;
  vec_t roll_nxt, yaw_nxt;

  always_comb begin
    a_full = (SW'(wy_r) - SW'(xz_r)) <<< 1;
    if (a_full > ONE_Q30)        a_sat = AW_IN'(ONE_Q30);
    else if (a_full < -ONE_Q30)  a_sat = AW_IN'(-ONE_Q30);
    else                         a_sat = AW_IN'(a_full);
    roll_nxt.y = (SW'(yz_r) + SW'(wx_r)) <<< 1;
    roll_nxt.x = ONE_Q30 - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
    yaw_nxt.y  = (SW'(xy_r) + SW'(wz_r)) <<< 1;
    yaw_nxt.x  = SW'(ww_r) + SW'(xx_r) - SW'(yy_r) - SW'(zz_r);
  end

  logic v2_r;
  logic signed [AW_IN-1:0] a2_r;
  vec_t roll2_r, yaw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    a2_r    <= a_sat;
    roll2_r <= roll_nxt;
    yaw2_r  <= yaw_nxt;
  end

  // stage 3: 2^60 - a^2
  logic signed [2*AW_IN-1:0] a_sq;
  assign a_sq = a2_r * a2_r;

  logic v3_r;
  logic [RAD_W-1:0] rad3_r;
  logic signed [AW_IN-1:0] a3_r;
  vec_t roll3_r, yaw3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    rad3_r  <= RAD_W'((64'd1 << 60) - 64'(a_sq));
    a3_r    <= a2_r;
    roll3_r <= roll2_r;
    yaw3_r  <= yaw2_r;
  end

  assign out_vld  = v3_r;
  assign asin_arg = a3_r;
  assign radicand = rad3_r;
  assign roll_vec = roll3_r;
  assign yaw_vec  = yaw3_r;

endmodule

`default_nettype wire

@@ hw/rtl/qte_sqrt.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage,
// with a side payload delayed alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt
  import qte_pkg::*;
#(
  parameter int SIDE_W = 8
)(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_vld,
  input  wire  [RAD_W-1:0]    radicand,
  input  wire  [SIDE_W-1:0]   side_in,
  output logic                out_vld,
  output logic [ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RW  = 2 * ROOT_W;   // padded radicand
  localparam int RMW = ROOT_W + 2;   // partial remainder
  localparam int TW  = RMW + 2;      // shifted remainder / trial

  logic              v_r    [ROOT_W];
  logic [RW-1:0]     rad_r  [ROOT_W];
  logic [RMW-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [RW-1:0]     rad_in;
    logic [RMW-1:0]    rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_x;
    logic [TW-1:0]     rs, trial;
    logic [RMW-1:0]    rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rad_in  = RW'(radicand);
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_x  = side_in;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_x  = side_r[k-1];
    end

    always_comb begin
      rs    = {rem_in, rad_in[RW-1-2*k -: 2]};
      trial = TW'({root_in, 2'b01});
      if (rs >= trial) begin
        rem_nxt  = RMW'(rs - trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = RMW'(rs);
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else        v_r[k] <= v_in;
      rad_r[k]  <= rad_in;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      side_r[k] <= side_x;
    end
  end

  assign out_vld  = v_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign side_out = side_r[ROOT_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic
// Unrolled vectoring CORDIC atan2, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic
  import qte_pkg::*;
#(
  parameter int ANGLE_FRACTION_BITS = 16,
  parameter int CORDIC_STAGES       = 16
)(
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_vld,
  input  wire  signed [CW-1:0]                   vec_y,
  input  wire  signed [CW-1:0]                   vec_x,
  output logic                                   out_vld,
  output logic signed [ANGLE_FRACTION_BITS+4:0]  angle
);

  localparam int AW = ANGLE_FRACTION_BITS + 5;
  localparam logic signed [AW-1:0] PI_A = AW'(pi_angle(ANGLE_FRACTION_BITS));

  // pre-rotation: quadrant fold and the y == 0 cases
  logic signed [CW-1:0] x0_nxt, y0_nxt;
  logic signed [AW-1:0] z0_nxt;
  logic                 byp0_nxt;

  always_comb begin
    x0_nxt   = vec_x;
    y0_nxt   = vec_y;
    z0_nxt   = '0;
    byp0_nxt = (vec_y == '0);
    if (byp0_nxt) begin
      z0_nxt = vec_x[CW-1] ? PI_A : '0;
    end else if (vec_x[CW-1]) begin
      z0_nxt = (vec_y > 0) ? PI_A : -PI_A;
      x0_nxt = -vec_x;
      y0_nxt = -vec_y;
    end
  end

  logic                 v_r   [CORDIC_STAGES+1];
  logic                 byp_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] x_r   [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r   [CORDIC_STAGES+1];
  logic signed [AW-1:0] z_r   [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= in_vld;
    byp_r[0] <= byp0_nxt;
    x_r[0]   <= x0_nxt;
    y_r[0]   <= y0_nxt;
    z_r[0]   <= z0_nxt;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [AW-1:0] ATAN_I = AW'(atan_angle(i, ANGLE_FRACTION_BITS));
    logic signed [CW-1:0] x_nxt, y_nxt;
    logic signed [AW-1:0] z_nxt;

    always_comb begin
      x_nxt = x_r[i];
      y_nxt = y_r[i];
      z_nxt = z_r[i];
      if (!byp_r[i]) begin
        if (!y_r[i][CW-1]) begin
          x_nxt = x_r[i] + (y_r[i] >>> i);
          y_nxt = y_r[i] - (x_r[i] >>> i);
          z_nxt = z_r[i] + ATAN_I;
        end else begin
          x_nxt = x_r[i] - (y_r[i] >>> i);
          y_nxt = y_r[i] + (x_r[i] >>> i);
          z_nxt = z_r[i] - ATAN_I;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else        v_r[i+1] <= v_r[i];
      byp_r[i+1] <= byp_r[i];
      x_r[i+1]   <= x_nxt;
      y_r[i+1]   <= y_nxt;
      z_r[i+1]   <= z_nxt;
    end
  end

  assign out_vld = v_r[CORDIC_STAGES];
  assign angle   = z_r[CORDIC_STAGES];

endmodule

`default_nettype wire

@@ hw/rtl/qte_scale.sv @@
// ----------------------------------------------------------------------------
// qte_scale
// Radians to hundredths of a degree, offset add and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_scale
  import qte_pkg::*;
#(
  parameter int ANGLE_FRACTION_BITS = 16
)(
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_vld,
  input  wire  signed [ANGLE_FRACTION_BITS+4:0] angle,
  input  wire  signed [OFF_W-1:0]               offset,
  output logic                                  out_vld,
  output logic signed [OUT_W-1:0]               result
);

  localparam int AW = ANGLE_FRACTION_BITS + 5;
  localparam int MW = AW + 14;
  localparam int HW = 24;
  localparam logic signed [13:0] K_DEG = 14'(HUNDREDTHS_PER_RAD);
  localparam logic signed [MW-1:0] HALF = MW'(64'sd1 <<< (ANGLE_FRACTION_BITS - 1));
  localparam logic signed [HW-1:0] LIM = HW'(ANGLE_LIMIT);

  logic                 v1_r;
  logic signed [MW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
    prod_r <= MW'(angle * K_DEG);
  end

  logic signed [MW-1:0] rnd;
  logic signed [HW-1:0] h;
  logic signed [OUT_W-1:0] res_nxt;

  always_comb begin
    rnd = (prod_r + HALF) >>> ANGLE_FRACTION_BITS;
    h   = HW'(rnd) + HW'(offset);
    if (h > LIM)        res_nxt = OUT_W'(LIM);
    else if (h < -LIM)  res_nxt = OUT_W'(-LIM);
    else                res_nxt = OUT_W'(h);
  end

  logic                    v2_r;
  logic signed [OUT_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    res_r <= res_nxt;
  end

  assign out_vld = v2_r;
  assign result  = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/quaternion_to_euler_angles_core.sv @@
// Pipeline from accepting transfer to out_valid: 4 front stages, 31 square-root
// stages, CORDIC_STAGES+1 CORDIC stages and 2 scaling stages. Throughput: one
// sample per clock, set by the fully unrolled root and CORDIC pipelines; busy is
// never raised.
// Synchronous active-low reset clears all valid bits and loads the offsets.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Pipelined quaternion to pitch/roll/yaw converter with calibration offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_core
  import qte_pkg::*;
#(
  parameter int ANGLE_FRACTION_BITS = 16,
  parameter int CORDIC_STAGES       = 16
)(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire  signed [QW-1:0]    in_quat_w,
  input  wire  signed [QW-1:0]    in_quat_x,
  input  wire  signed [QW-1:0]    in_quat_y,
  input  wire  signed [QW-1:0]    in_quat_z,
  input  wire                     in_has_quaternion,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_pitch_angle,
  output logic signed [OUT_W-1:0] out_roll_angle,
  output logic signed [OUT_W-1:0] out_yaw_angle,
  input  wire                     cfg_we,
  input  wire  [1:0]              cfg_index,
  input  wire  [OFF_W-1:0]        cfg_wdata
);

  localparam int AW = ANGLE_FRACTION_BITS + 5;
  localparam int SIDE_W = AW_IN + 4 * SW;
  localparam int LATENCY = CORDIC_STAGES + 38;

  assign busy = 1'b0;

  // calibration offsets
  logic signed [OFF_W-1:0] pitch_off_r, roll_off_r, yaw_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_off_r <= -16'sd83;
      roll_off_r  <= 16'sd84;
      yaw_off_r   <= -16'sd1042;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PITCH_OFFSET: pitch_off_r <= cfg_wdata;
        CFG_ROLL_OFFSET:  roll_off_r  <= cfg_wdata;
        CFG_YAW_OFFSET:   yaw_off_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end
  logic                    fr_vld;
  logic signed [AW_IN-1:0] fr_a;
  logic [RAD_W-1:0]        fr_rad;
  vec_t                    fr_roll, fr_yaw;

  qte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy && in_has_quaternion),
    .quat_w   (in_quat_w),
    .quat_x   (in_quat_x),
    .quat_y   (in_quat_y),
    .quat_z   (in_quat_z),
    .out_vld  (fr_vld),
    .asin_arg (fr_a),
    .radicand (fr_rad),
    .roll_vec (fr_roll),
    .yaw_vec  (fr_yaw)
  );

  // cosine of pitch; roll/yaw vectors ride along
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side;
  logic signed [AW_IN-1:0] sq_a;
  vec_t sq_roll, sq_yaw;

  qte_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .radicand (fr_rad),
    .side_in  ({fr_a, fr_roll, fr_yaw}),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  assign {sq_a, sq_roll, sq_yaw} = sq_side;

  // three atan2 lanes
  logic                 pc_vld, rc_vld, yc_vld;
  logic signed [AW-1:0] pc_ang, rc_ang, yc_ang;

  qte_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES))
  u_cordic_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .vec_y   (CW'(sq_a)),
    .vec_x   (CW'(signed'({1'b0, sq_root}))),
    .out_vld (pc_vld),
    .angle   (pc_ang)
  );

  qte_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES))
  u_cordic_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .vec_y   (CW'(sq_roll.y)),
    .vec_x   (CW'(sq_roll.x)),
    .out_vld (rc_vld),
    .angle   (rc_ang)
  );

  qte_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES))
  u_cordic_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .vec_y   (CW'(sq_yaw.y)),
    .vec_x   (CW'(sq_yaw.x)),
    .out_vld (yc_vld),
    .angle   (yc_ang)
  );

  // scaling and offsets
  logic ps_vld, rs_vld, ys_vld;

  qte_scale #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_scale_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (pc_vld),
    .angle   (pc_ang),
    .offset  (pitch_off_r),
    .out_vld (ps_vld),
    .result  (out_pitch_angle)
  );

  qte_scale #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_scale_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rc_vld),
    .angle   (rc_ang),
    .offset  (roll_off_r),
    .out_vld (rs_vld),
    .result  (out_roll_angle)
  );

  qte_scale #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_scale_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (yc_vld),
    .angle   (yc_ang),
    .offset  (yaw_off_r),
    .out_vld (ys_vld),
    .result  (out_yaw_angle)
  );

  // lanes run in lockstep
  assign out_valid = ps_vld && rs_vld && ys_vld;

endmodule

`default_nettype wire

@@ hw/rtl/qte_checker.sv @@
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks of the quaternion to Euler core.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_checker
  import qte_pkg::*;
#(
  parameter int LATENCY = 54
)(
  input wire                     clk,
  input wire                     rst_n,
  input wire                     start,
  input wire                     busy,
  input wire                     in_has_quaternion,
  input wire                     out_valid,
  input wire signed [OUT_W-1:0]  out_pitch_angle,
  input wire signed [OUT_W-1:0]  out_roll_angle,
  input wire signed [OUT_W-1:0]  out_yaw_angle
);

  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(ANGLE_LIMIT);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transfer right after reset");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_has_quaternion, LATENCY))
    else $error("result transfer without a matching quaternion sample");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= LIM && out_pitch_angle >= -LIM &&
                   out_roll_angle <= LIM && out_roll_angle >= -LIM &&
                   out_yaw_angle <= LIM && out_yaw_angle >= -LIM))
    else $error("angle outside clamp range");

endmodule

bind quaternion_to_euler_angles_core qte_checker #(.LATENCY(LATENCY)) u_qte_checker (.*);

`default_nettype wire
